/* rtl/core/odsl_pkg.sv */
// Shared types, codes and helpers for the omitted-date lookup unit.
`default_nettype none
package odsl_pkg;

    localparam int MODE_W  = 3;
    localparam int DAY_W   = 23;
    localparam int DKEY_W  = DAY_W - 1;   // non-negative day numbers only
    localparam int PKEY_W  = 9;           // month*32 + day_of_month
    localparam int WEEK_LEN    = 7;
    localparam int MONTH_SHIFT = 5;
    localparam logic [WEEK_LEN-1:0] ALL_WEEKDAYS = 7'h7F;

    localparam logic [MODE_W-1:0] MODE_QUERY    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_ADD_FULL = 3'd1;
    localparam logic [MODE_W-1:0] MODE_ADD_PART = 3'd2;
    localparam logic [MODE_W-1:0] MODE_ADD_WDAY = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CLEAR    = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL_FULL = 2'd1;
    localparam logic [1:0] ST_ALL_WDAYS = 2'd2;
    localparam logic [1:0] ST_PART_FULL = 2'd3;

    typedef struct packed {
        logic search;
        logic insert;
    } t_set_cmd;

    typedef struct packed {
        logic done;
        logic found;
    } t_set_rsp;

    // Floor modulo 7 of a 23-bit two's-complement day number.
    // Octal digits fold because 8 = 1 (mod 7); 2^23 = 4 (mod 7) fixes the sign.
    function automatic logic [2:0] day_mod7(input logic [DAY_W-1:0] raw);
        logic [5:0] s1;
        logic [3:0] s2;
        logic [3:0] s3;
        logic [2:0] u;
        s1 = 6'(raw[2:0]) + 6'(raw[5:3]) + 6'(raw[8:6]) + 6'(raw[11:9])
           + 6'(raw[14:12]) + 6'(raw[17:15]) + 6'(raw[20:18]) + 6'(raw[22:21]);
        s2 = 4'(s1[2:0]) + 4'(s1[5:3]);
        s3 = 4'(s2[2:0]) + 4'(s2[3]);
        u  = (s3 >= 4'd7) ? 3'(s3 - 4'd7) : s3[2:0];
        if (raw[DAY_W-1]) begin
            day_mod7 = (u >= 3'd4) ? 3'(u - 3'd4) : 3'(u + 3'd3);
        end else begin
            day_mod7 = u;
        end
    endfunction

endpackage
`default_nettype wire

/* rtl/core/omitted_date_set_lookup_unit.sv */
// Top level of the omitted-date lookup unit: sequencer, weekday mask and counts.
//
// Usage: one input word (i_valid/o_ready) carries a mode and its operands; the
// unit answers each word with exactly one result word (o_valid/i_ready).
// Modes: query a date, add a day number, add a month/day key, OR in weekday
// bits, clear all. Queries test day_number mod 7 against the local and global
// masks, then binary-search the full set (non-negative days only), then the partial set.
// Each search probe reads one table entry and then compares it; an insert
// starts and then shifts entries up one at a time. Mask and clear words,
// and full-set adds rejected at dispatch, need no search. The single-ported
// table in each set store does one access at a time; o_ready is high only
// between words, so one word is worked on at a time.
// The result sits in an output register; a new word is accepted while it
// waits, and if the receiver stalls the next result is held until it drains.
// Reset clears both counts, the weekday mask and all handshake state. Table
// contents are left as they are: only entries below the counts are ever read.
`default_nettype none
module omitted_date_set_lookup_unit #(
    parameter int FULL_DEPTH    = 1024,
    parameter int PARTIAL_DEPTH = 512
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_valid,
    output logic                        o_ready,
    input  wire  [2:0]                  i_mode,
    input  wire  signed [22:0]          i_day_number,
    input  wire  [3:0]                  i_month_index,
    input  wire  [4:0]                  i_day_of_month,
    input  wire  [6:0]                  i_local_weekday_mask,
    input  wire  [6:0]                  i_weekday_bits,
    output logic                        o_valid,
    input  wire                         i_ready,
    output logic                        o_omitted,
    output logic [1:0]                  o_status,
    output logic [10:0]                 o_full_count,
    output logic [9:0]                  o_partial_count
);
    import odsl_pkg::*;

    localparam int FCNT_W = $clog2(FULL_DEPTH + 1);
    localparam int PCNT_W = $clog2(PARTIAL_DEPTH + 1);

    localparam logic [2:0] T_IDLE  = 3'd0;
    localparam logic [2:0] T_DISP  = 3'd1;
    localparam logic [2:0] T_FSRCH = 3'd2;
    localparam logic [2:0] T_PSRCH = 3'd3;
    localparam logic [2:0] T_FINS  = 3'd4;
    localparam logic [2:0] T_PINS  = 3'd5;
    localparam logic [2:0] T_FIN   = 3'd6;

    logic [2:0]          r_state, n_state;
    logic [MODE_W-1:0]   r_mode;
    logic [DAY_W-1:0]    r_day;
    logic [PKEY_W-1:0]   r_pkey;
    logic [WEEK_LEN-1:0] r_local, r_wbits;

    logic [FCNT_W-1:0]   r_fcnt, n_fcnt;
    logic [PCNT_W-1:0]   r_pcnt, n_pcnt;
    logic [WEEK_LEN-1:0] r_gmask, n_gmask;
    logic                r_res_omit, n_res_omit;
    logic [1:0]          r_res_status, n_res_status;

    logic                r_out_valid, n_out_valid;
    logic                r_out_omit;
    logic [1:0]          r_out_status;
    logic [FCNT_W-1:0]   r_out_fcnt;
    logic [PCNT_W-1:0]   r_out_pcnt;
    logic                out_load;

    t_set_cmd            f_cmd, p_cmd;
    t_set_rsp            f_rsp, p_rsp;

    logic                accept;
    logic                day_neg;
    logic [WEEK_LEN-1:0] wday_bit;
    logic [FCNT_W+10:0]  fcnt_ext;
    logic [PCNT_W+9:0]   pcnt_ext;

    assign accept   = i_valid && o_ready;
    assign o_ready  = (r_state == T_IDLE);
    assign day_neg  = r_day[DAY_W-1];
    assign wday_bit = WEEK_LEN'(1) << day_mod7(r_day);

    // Full set holds only non-negative days, so the sign bit is dropped.
    odsl_sorted_set #(
        .DEPTH (FULL_DEPTH),
        .KEY_W (DKEY_W),
        .CNT_W (FCNT_W)
    ) u_full_set (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (f_cmd),
        .i_key   (r_day[DKEY_W-1:0]),
        .i_count (r_fcnt),
        .o_rsp   (f_rsp)
    );

    odsl_sorted_set #(
        .DEPTH (PARTIAL_DEPTH),
        .KEY_W (PKEY_W),
        .CNT_W (PCNT_W)
    ) u_part_set (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (p_cmd),
        .i_key   (r_pkey),
        .i_count (r_pcnt),
        .o_rsp   (p_rsp)
    );

    // Sequencer
    always_comb begin
        n_state      = r_state;
        n_fcnt       = r_fcnt;
        n_pcnt       = r_pcnt;
        n_gmask      = r_gmask;
        n_res_omit   = r_res_omit;
        n_res_status = r_res_status;
        f_cmd        = '0;
        p_cmd        = '0;
        out_load     = 1'b0;
        unique case (r_state)
            T_IDLE: begin
                n_res_omit   = 1'b0;
                n_res_status = ST_OK;
                if (accept) begin
                    n_state = T_DISP;
                end
            end
            T_DISP: begin
                n_state = T_FIN;
                unique case (r_mode)
                    MODE_QUERY: begin
                        if (|((r_local | r_gmask) & wday_bit)) begin
                            n_res_omit = 1'b1;
                        end else if (day_neg) begin
                            p_cmd.search = 1'b1;
                            n_state      = T_PSRCH;
                        end else begin
                            f_cmd.search = 1'b1;
                            n_state      = T_FSRCH;
                        end
                    end
                    MODE_ADD_FULL: begin
                        if (day_neg) begin
                            n_res_status = ST_OK;
                        end else if (r_fcnt >= FCNT_W'(FULL_DEPTH)) begin
                            n_res_status = ST_FULL_FULL;
                        end else begin
                            f_cmd.search = 1'b1;
                            n_state      = T_FSRCH;
                        end
                    end
                    MODE_ADD_PART: begin
                        p_cmd.search = 1'b1;
                        n_state      = T_PSRCH;
                    end
                    MODE_ADD_WDAY: begin
                        if ((r_gmask | r_wbits) == ALL_WEEKDAYS) begin
                            n_res_status = ST_ALL_WDAYS;
                        end else begin
                            n_gmask = r_gmask | r_wbits;
                        end
                    end
                    MODE_CLEAR: begin
                        n_fcnt  = '0;
                        n_pcnt  = '0;
                        n_gmask = '0;
                    end
                    default: begin
                    end
                endcase
            end
            T_FSRCH: begin
                if (f_rsp.done) begin
                    if (r_mode == MODE_QUERY) begin
                        if (f_rsp.found) begin
                            n_res_omit = 1'b1;
                            n_state    = T_FIN;
                        end else begin
                            p_cmd.search = 1'b1;
                            n_state      = T_PSRCH;
                        end
                    end else if (f_rsp.found) begin
                        n_state = T_FIN;       // duplicate dropped
                    end else begin
                        n_state = T_FINS;
                    end
                end
            end
            T_PSRCH: begin
                if (p_rsp.done) begin
                    n_state = T_FIN;
                    if (r_mode == MODE_QUERY) begin
                        n_res_omit = p_rsp.found;
                    end else if (!p_rsp.found) begin
                        if (r_pcnt >= PCNT_W'(PARTIAL_DEPTH)) begin
                            n_res_status = ST_PART_FULL;
                        end else begin
                            n_state = T_PINS;
                        end
                    end
                end
            end
            T_FINS: begin
                // store is idle on entry and takes the insert then; ignored while busy
                f_cmd.insert = 1'b1;
                if (f_rsp.done) begin
                    n_fcnt  = r_fcnt + FCNT_W'(1);
                    n_state = T_FIN;
                end
            end
            T_PINS: begin
                p_cmd.insert = 1'b1;
                if (p_rsp.done) begin
                    n_pcnt  = r_pcnt + PCNT_W'(1);
                    n_state = T_FIN;
                end
            end
            T_FIN: begin
                // hold until the output register is free
                if (!r_out_valid || i_ready) begin
                    out_load = 1'b1;
                    n_state  = T_IDLE;
                end
            end
            default: begin
                n_state = T_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= T_IDLE;
            r_fcnt      <= '0;
            r_pcnt      <= '0;
            r_gmask     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fcnt      <= n_fcnt;
            r_pcnt      <= n_pcnt;
            r_gmask     <= n_gmask;
            r_out_valid <= n_out_valid;
        end
        r_res_omit   <= n_res_omit;
        r_res_status <= n_res_status;
        if (accept) begin
            r_mode  <= i_mode;
            r_day   <= i_day_number;
            r_pkey  <= (PKEY_W'(i_month_index) << MONTH_SHIFT) + PKEY_W'(i_day_of_month);
            r_local <= i_local_weekday_mask;
            r_wbits <= i_weekday_bits;
        end
        if (out_load) begin
            r_out_omit   <= r_res_omit;
            r_out_status <= r_res_status;
            r_out_fcnt   <= r_fcnt;
            r_out_pcnt   <= r_pcnt;
        end
    end

    // Counts go out as their low bits, zero-extended where narrower.
    assign fcnt_ext = {11'b0, r_out_fcnt};
    assign pcnt_ext = {10'b0, r_out_pcnt};

    assign o_valid         = r_out_valid;
    assign o_omitted       = r_out_omit;
    assign o_status        = r_out_status;
    assign o_full_count    = fcnt_ext[10:0];
    assign o_partial_count = pcnt_ext[9:0];

endmodule
`default_nettype wire

/* rtl/core/odsl_sorted_set.sv */
// Sorted key store with iterative binary search and shift-up insert.
`default_nettype none
module odsl_sorted_set #(
    parameter int DEPTH = 1024,
    parameter int KEY_W = 22,
    parameter int CNT_W = 11
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  odsl_pkg::t_set_cmd    i_cmd,
    input  wire  [KEY_W-1:0]      i_key,
    input  wire  [CNT_W-1:0]      i_count,
    output odsl_pkg::t_set_rsp    o_rsp
);
    import odsl_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SRCH = 3'd1;
    localparam logic [2:0] S_SCMP = 3'd2;
    localparam logic [2:0] S_INS  = 3'd3;
    localparam logic [2:0] S_ICMP = 3'd4;

    logic [KEY_W-1:0] r_mem [DEPTH];
    logic [KEY_W-1:0] r_rd;

    logic [2:0]       r_state, n_state;
    logic [CNT_W-1:0] r_lo, n_lo, r_hi, n_hi, r_mid, n_mid, r_pos, n_pos;
    logic [KEY_W-1:0] r_key, n_key;

    logic             rd_en, wr_en;
    logic [CNT_W-1:0] rd_cnt, wr_cnt;
    logic [KEY_W-1:0] wr_data;
    logic [CNT_W-1:0] mid_calc;
    logic [CNT_W-1:0] pos_m1;

    assign mid_calc = r_lo + ((r_hi - r_lo) >> 1);
    assign pos_m1   = r_pos - CNT_W'(1);

    always_comb begin
        n_state = r_state;
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_mid   = r_mid;
        n_pos   = r_pos;
        n_key   = r_key;
        rd_en   = 1'b0;
        rd_cnt  = '0;
        wr_en   = 1'b0;
        wr_cnt  = r_pos;
        wr_data = r_key;
        o_rsp   = '0;
        unique case (r_state)
            S_IDLE: begin
                n_key = i_key;
                n_lo  = '0;
                n_hi  = i_count;
                n_pos = i_count;
                if (i_cmd.search) begin
                    n_state = S_SRCH;
                end else if (i_cmd.insert) begin
                    n_state = S_INS;
                end
            end
            S_SRCH: begin
                if (r_lo >= r_hi) begin
                    o_rsp.done = 1'b1;
                    n_state    = S_IDLE;
                end else begin
                    n_mid   = mid_calc;
                    rd_en   = 1'b1;
                    rd_cnt  = mid_calc;
                    n_state = S_SCMP;
                end
            end
            S_SCMP: begin
                if (r_rd == r_key) begin
                    o_rsp.done  = 1'b1;
                    o_rsp.found = 1'b1;
                    n_state     = S_IDLE;
                end else begin
                    if (r_rd > r_key) begin
                        n_hi = r_mid;
                    end else begin
                        n_lo = r_mid + CNT_W'(1);
                    end
                    n_state = S_SRCH;
                end
            end
            S_INS: begin
                if (r_pos == '0) begin
                    wr_en      = 1'b1;
                    o_rsp.done = 1'b1;
                    n_state    = S_IDLE;
                end else begin
                    rd_en   = 1'b1;
                    rd_cnt  = pos_m1;
                    n_state = S_ICMP;
                end
            end
            S_ICMP: begin
                wr_en = 1'b1;
                if (r_rd > r_key) begin
                    wr_data = r_rd;
                    n_pos   = pos_m1;
                    n_state = S_INS;
                end else begin
                    o_rsp.done = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd <= r_mem[rd_cnt[IDX_W-1:0]];
        end
        if (wr_en) begin
            r_mem[wr_cnt[IDX_W-1:0]] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_lo  <= n_lo;
        r_hi  <= n_hi;
        r_mid <= n_mid;
        r_pos <= n_pos;
        r_key <= n_key;
    end

endmodule
`default_nettype wire
